### design/lifo_stack_with_indexed_access_assert.svh
// assertion macros for the lifo stack block
`ifndef LIFO_STACK_WITH_INDEXED_ACCESS_ASSERT_SVH
`define LIFO_STACK_WITH_INDEXED_ACCESS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every edge outside reset
`define LSIA_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked on every edge, reset included
`define LSIA_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LSIA_ASSERT(lbl, clock, reset, prop, msg)
`define LSIA_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### design/lsia_pkg.sv
// shared types and codes for the lifo stack block
package lsia_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  localparam logic [1:0] MODE_CHANGE = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### design/lsia_ram.sv
// single-port-write, registered-read word store for the lifo stack
module lsia_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lifo_stack_with_indexed_access.sv
// lifo stack of signed 32-bit words with positional peek and change
// a request is accepted in the idle state and executed in the exec state, where its result
//   is registered once the result channel holds no earlier result still waiting
// one request at a time: no new request is accepted until the current one has executed,
//   as the registered read of the word store comes before the read-modify-write of the same entry
// reset: synchronous; after reset a clearing pass writes zero to all DEPTH entries,
//   one a cycle, during which no request is accepted
`include "lifo_stack_with_indexed_access_assert.svh"

module lifo_stack_with_indexed_access #(
  parameter int DEPTH = lsia_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_in [31:0], slot_position [36:32], zero pad
  input  logic [1:0]  s_tuser,   // mode [1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // data_out [31:0], status [33:32], fill_count [38:34],
                                 // is_empty [39], is_full [40], zero pad
);

  import lsia_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // control state
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] clr_addr;

  // latched request
  logic [1:0]    req_mode;
  logic [31:0]   req_data;
  logic [4:0]    req_pos;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // result of the request being executed
  logic [31:0]   res_data;
  logic [1:0]    res_status;

  // helpers
  logic          accept;
  logic          exec_go;
  logic          is_empty_now;
  logic          is_full_now;
  logic          req_pos_ok;
  logic [4:0]    in_pos_dec;
  logic [4:0]    req_pos_dec;
  logic [AW+4:0] in_pos_ext;
  logic [AW+4:0] req_pos_ext;
  logic [CW-1:0] count_dec;
  logic [CW+4:0] count_next_ext;

  assign accept  = s_tvalid && s_tready;
  // the result register must be free, or emptied this cycle, before execution
  assign exec_go = (state == S_EXEC) && (!m_tvalid || m_tready);

  assign is_empty_now = (count == '0);
  assign is_full_now  = (count >= CW'(DEPTH));
  assign count_dec    = count - 1'b1;

  // 1-based position check and 0-based slot index, for incoming and latched request
  assign req_pos_ok  = (req_pos != 5'd0) && (32'(req_pos) <= 32'(DEPTH));
  assign in_pos_dec  = s_tdata[36:32] - 5'd1;
  assign req_pos_dec = req_pos - 5'd1;
  assign in_pos_ext  = {{AW{1'b0}}, in_pos_dec};
  assign req_pos_ext = {{AW{1'b0}}, req_pos_dec};

  // word store
  lsia_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs of the sequencer: handshake, memory access, result of the request
  always_comb begin
    s_tready   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = in_pos_ext[AW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    res_data   = '0;
    res_status = STATUS_OK;
    count_next = count;
    unique case (state)
      S_CLEAR: begin
        // sweep zero through the store
        mem_we = 1'b1;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        // pop reads the top word, peek the addressed one
        mem_re = accept;
        if (s_tuser == MODE_POP) begin
          mem_raddr = count_dec[AW-1:0];
        end
      end
      S_EXEC: begin
        case (req_mode)
          MODE_PUSH: begin
            if (is_full_now) begin
              res_status = STATUS_FULL;
            end else begin
              mem_we     = exec_go;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = req_data;
              count_next = count + 1'b1;
            end
          end
          MODE_POP: begin
            if (is_empty_now) begin
              res_status = STATUS_EMPTY;
            end else begin
              // hand out the top word and leave its slot zero
              res_data   = mem_rdata;
              mem_we     = exec_go;
              mem_waddr  = count_dec[AW-1:0];
              count_next = count_dec;
            end
          end
          MODE_PEEK: begin
            // empty takes precedence over a bad position
            if (is_empty_now) begin
              res_status = STATUS_EMPTY;
            end else if (!req_pos_ok) begin
              res_status = STATUS_BADPOS;
            end else begin
              res_data = mem_rdata;
            end
          end
          default: begin
            // change: allowed above the top and on an empty stack
            if (!req_pos_ok) begin
              res_status = STATUS_BADPOS;
            end else begin
              mem_we    = exec_go;
              mem_waddr = req_pos_ext[AW-1:0];
              mem_wdata = req_data;
            end
          end
        endcase
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // fill count is reported in its low five bits
  assign count_next_ext = {5'd0, count_next};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (exec_go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= s_tuser;
      req_data <= s_tdata[31:0];
      req_pos  <= s_tdata[36:32];
    end
    if (exec_go) begin
      m_tdata <= {7'd0,
                  (count_next >= CW'(DEPTH)),
                  (count_next == '0),
                  count_next_ext[4:0],
                  res_status,
                  res_data};
    end
  end

  // checks on the sequencer and the stack pointer
  `LSIA_ASSERT(a_count_range, clk, rst, (count <= CW'(DEPTH)), "fill count above depth")
  `LSIA_ASSERT(a_no_accept_clear, clk, rst, ((state == S_CLEAR) |-> !s_tready),
               "request accepted during clearing pass")
  `LSIA_ASSERT(a_accept_exec, clk, rst, (accept |=> (state == S_EXEC)),
               "accepted request not executed")
  `LSIA_ASSERT(a_push_grows, clk, rst,
               ((exec_go && (req_mode == MODE_PUSH) && !is_full_now)
                |=> (count == $past(count) + 1'b1)),
               "push did not raise fill count")

endmodule

### dv/testbench.sv
// self-checking testbench for the lifo stack with positional peek and change
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsia_pkg::*;

  localparam int WORDS = DEPTH_DEFAULT;
  localparam int ITEMS_PER_PHASE = 435;
  localparam int REPORT_LIMIT = 10;

  // one reply of the stack, as carried on m_tdata
  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [4:0]         fill_count;
    logic               is_empty;
    logic               is_full;
  } stack_reply_t;

  // one row of the directed table; a typed reply is checked as written
  typedef struct packed {
    logic [1:0]   mode;
    logic [31:0]  word;
    logic [4:0]   pos;
    logic [4:0]   reps;
    logic         typed;
    stack_reply_t reply;
  } directed_row_t;

  localparam stack_reply_t UNTYPED = '0;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_in [31:0], slot_position [36:32], zero pad
  logic [1:0]  s_tuser;   // mode [1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // data_out [31:0], status [33:32], fill_count [38:34],
                          // is_empty [39], is_full [40], zero pad

  // own copy of the stack contents and fill level
  logic signed [31:0] stack_words [WORDS];
  int                 stack_fill;

  stack_reply_t replies_due [$];
  int           fault_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  lifo_stack_with_indexed_access #(.DEPTH(WORDS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous ceiling: far beyond the slowest run with both sides stalling
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic bit slot_valid(logic [4:0] pos);
    return pos >= 1 && pos <= WORDS;
  endfunction

  // applies one request to the stack copy and returns the reply it gives
  function automatic stack_reply_t stack_apply(logic [1:0] mode, logic [31:0] word,
                                               logic [4:0] pos);
    stack_reply_t r;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_PUSH: begin
        if (stack_fill >= WORDS) begin
          r.status = STATUS_FULL;
        end else begin
          stack_words[stack_fill] = word;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          stack_fill--;
          r.data_out = stack_words[stack_fill];
          stack_words[stack_fill] = '0;
        end
      end
      MODE_PEEK: begin
        // emptiness wins over a bad position
        if (stack_fill == 0) r.status = STATUS_EMPTY;
        else if (!slot_valid(pos)) r.status = STATUS_BADPOS;
        else r.data_out = stack_words[pos - 1];
      end
      default: begin
        // change may write above the top, even on an empty stack
        if (!slot_valid(pos)) r.status = STATUS_BADPOS;
        else stack_words[pos - 1] = word;
      end
    endcase
    r.fill_count = stack_fill[4:0];
    r.is_empty   = (stack_fill == 0);
    r.is_full    = (stack_fill >= WORDS);
    return r;
  endfunction

  function automatic void note_fault(string what, stack_reply_t want, stack_reply_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%s: expected data %0d status %0d fill %0d empty %0b full %0b,",
               what, want.data_out, want.status, want.fill_count, want.is_empty,
               want.is_full);
      $display("  got data %0d status %0d fill %0d empty %0b full %0b",
               got.data_out, got.status, got.fill_count, got.is_empty, got.is_full);
    end
  endfunction

  // drives one request and holds it until taken; valid only drops across a gap,
  // so it never gets two assignments in one step
  task automatic send_request(logic [1:0] mode, logic [31:0] word, logic [4:0] pos,
                              logic typed, stack_reply_t given);
    stack_reply_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 40'({$urandom, $urandom});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pos, word};
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = stack_apply(mode, word, pos);
    replies_due.push_back(typed ? given : r);
  endtask

  // receiver: checks each reply taken, then picks the next ready level
  initial begin
    stack_reply_t got;
    stack_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.data_out   = m_tdata[31:0];
        got.status     = m_tdata[33:32];
        got.fill_count = m_tdata[38:34];
        got.is_empty   = m_tdata[39];
        got.is_full    = m_tdata[40];
        if (replies_due.size() == 0) begin
          note_fault("reply with none due", UNTYPED, got);
        end else begin
          want = replies_due.pop_front();
          if (got.data_out != want.data_out || got.status != want.status ||
              got.fill_count != want.fill_count || got.is_empty != want.is_empty ||
              got.is_full != want.is_full)
            note_fault("reply mismatch", want, got);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    directed_row_t rows [13];
    logic [1:0]  mode;
    logic [31:0] word;
    logic [4:0]  pos;
    int          push_weight;
    int          pick;

    fault_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stack_fill     = 0;
    foreach (stack_words[i]) stack_words[i] = '0;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_PUSH;
    m_tready <= 1'b0;

    // empty stack corners, positions out of range, slot above the top, then full
    rows = '{
      '{MODE_POP,    32'h0,        5'd0,  5'd1,  1'b1, '{32'sd0, STATUS_EMPTY,  5'd0,  1'b1, 1'b0}},
      '{MODE_PEEK,   32'h0,        5'd1,  5'd1,  1'b1, '{32'sd0, STATUS_EMPTY,  5'd0,  1'b1, 1'b0}},
      '{MODE_CHANGE, 32'h7fffffff, 5'd16, 5'd1,  1'b1, '{32'sd0, STATUS_OK,     5'd0,  1'b1, 1'b0}},
      '{MODE_CHANGE, 32'hffffffff, 5'd0,  5'd1,  1'b1, '{32'sd0, STATUS_BADPOS, 5'd0,  1'b1, 1'b0}},
      '{MODE_CHANGE, 32'h80000000, 5'd31, 5'd1,  1'b1, '{32'sd0, STATUS_BADPOS, 5'd0,  1'b1, 1'b0}},
      '{MODE_PUSH,   32'h80000000, 5'd31, 5'd1,  1'b1, '{32'sd0, STATUS_OK,     5'd1,  1'b0, 1'b0}},
      '{MODE_PEEK,   32'h0,        5'd16, 5'd1,  1'b0, UNTYPED},
      '{MODE_PEEK,   32'h0,        5'd0,  5'd1,  1'b1, '{32'sd0, STATUS_BADPOS, 5'd1,  1'b0, 1'b0}},
      '{MODE_PEEK,   32'h0,        5'd17, 5'd1,  1'b1, '{32'sd0, STATUS_BADPOS, 5'd1,  1'b0, 1'b0}},
      '{MODE_PUSH,   32'hffffffff, 5'd0,  5'd15, 1'b0, UNTYPED},
      '{MODE_PUSH,   32'h12345678, 5'd1,  5'd1,  1'b1, '{32'sd0, STATUS_FULL,   5'd16, 1'b0, 1'b1}},
      '{MODE_PEEK,   32'h0,        5'd16, 5'd1,  1'b0, UNTYPED},
      '{MODE_POP,    32'h0,        5'd0,  5'd1,  1'b0, UNTYPED}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      repeat (rows[i].reps)
        send_request(rows[i].mode, rows[i].word, rows[i].pos, rows[i].typed, rows[i].reply);
    end

    // idling phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      push_weight = 55;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // swing between filling and draining so full and empty both recur
        if (n % 48 == 0) push_weight = (push_weight == 55) ? 15 : 55;
        pick = $urandom_range(99);
        if (pick < push_weight) mode = MODE_PUSH;
        else if (pick < 70) mode = MODE_POP;
        else if (pick < 85) mode = MODE_PEEK;
        else mode = MODE_CHANGE;
        case ($urandom_range(15))
          0: word = 32'h80000000;
          1: word = 32'h7fffffff;
          2: word = 32'hffffffff;
          3: word = 32'h0;
          default: word = $urandom;
        endcase
        // mostly good positions, some out of range on either side
        if ($urandom_range(9) == 0) pos = 5'($urandom_range(31));
        else pos = 5'($urandom_range(WORDS, 1));
        send_request(mode, word, pos, 1'b0, UNTYPED);
      end
    end

    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (replies_due.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lsia_pkg.sv
design/lsia_ram.sv
design/lifo_stack_with_indexed_access.sv
dv/testbench.sv
